// ===== rtl/bole_pkg.sv =====
// Package for the bounded ordered list engine.
// Holds the list depth, the action and status codes, and the cell control types.
// Depends on nothing; every other file of the block uses it.
package bole_pkg;

  // Number of cells in the chain, one list entry per cell.
  localparam int LIST_DEPTH = 16;
  // Width of the entry count, wide enough to hold LIST_DEPTH itself.
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  // Width of one list entry.
  localparam int VAL_W = 32;

  // Action codes of a request.
  localparam logic [2:0] ACT_INS_HEAD = 3'd0;
  localparam logic [2:0] ACT_APPEND   = 3'd1;
  localparam logic [2:0] ACT_DELETE   = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_DUMP     = 3'd4;

  // Status codes of a result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // What a cell does with its entry at each clock edge.
  typedef enum logic [2:0] {
    CELL_KEEP,    // hold the entry
    CELL_SHIFT,   // take the entry of the left neighbor (toward the head)
    CELL_LOAD,    // take the request value
    CELL_DELETE,  // take the right neighbor's entry at or after the first match
    CELL_ROTATE   // take the right neighbor's entry, or the head at the tail
  } cell_op_t;

  // Control that the top level hands to each cell.
  typedef struct packed {
    cell_op_t op;
    logic     valid;  // the cell holds a live entry
    logic     wrap;   // the cell holds the tail entry
  } cell_ctl_t;

endpackage

// ===== rtl/bounded_ordered_list_engine_unit.sv =====
// Top level of the bounded ordered list engine: control, count and the cell chain.
// Depends on bole_pkg and bole_cell.
//
// Usage:
//   A request (in_action, in_value) is taken at a rising edge where start is
//   high and busy is low. Results come on the out_ ports, each valid for exactly
//   one cycle while out_valid is high; the receiver takes every one of them.
//   Insert at head, append, delete, clear and unused codes give a single result
//   (out_last high) that appears the cycle after the request,
//   and a new request may follow in the very next cycle.
//   Dump of N entries rotates the chain once per cycle, reading the head cell:
//   busy stays high while the N entries are read, and the results appear one per
//   cycle once the state register is in the dump state, head first, out_last on the tail entry.
//   A dump of an empty list gives a single empty result the cycle after the request.
//   Insert shifts the whole chain and delete the cells from the first match on, in the same cycle;
//   the first-match flag ripples through the cells, which sets the delete path.
//   Reset (rst_n low, synchronous) empties the list and drops out_valid; the
//   cell contents are left as they are and never read until written again.
module bounded_ordered_list_engine_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_action,
  input  logic signed [bole_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic signed [bole_pkg::VAL_W-1:0] out_entry_value,
  output logic [4:0]                       out_entry_count,
  output logic                             out_last
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                        state_r;
  logic [bole_pkg::CNT_W-1:0]    count_r;
  logic [bole_pkg::CNT_W-1:0]    count_nxt;
  logic [bole_pkg::CNT_W-1:0]    idx_r;
  logic                          out_valid_r;
  logic [2:0]                    out_status_r;
  logic [bole_pkg::VAL_W-1:0]    out_value_r;
  logic [bole_pkg::CNT_W-1:0]    out_count_r;
  logic                          out_last_r;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          range_bad;
  logic                          found;
  logic [2:0]                    status;
  logic                          dump_last;
  logic [bole_pkg::VAL_W-1:0]    req_value;

  bole_pkg::cell_ctl_t           cell_ctl   [bole_pkg::LIST_DEPTH];
  logic [bole_pkg::VAL_W-1:0]    cell_value [bole_pkg::LIST_DEPTH];
  logic                          seen       [bole_pkg::LIST_DEPTH+1];

  assign busy      = (state_r == S_DUMP);
  assign accept    = start && !busy;
  assign req_value = in_value;
  assign full      = (count_r == bole_pkg::CNT_W'(bole_pkg::LIST_DEPTH));
  assign empty     = (count_r == '0);
  // Values outside the half range have their two top bits unequal.
  assign range_bad = (in_value[bole_pkg::VAL_W-1] != in_value[bole_pkg::VAL_W-2]);
  assign found     = seen[bole_pkg::LIST_DEPTH];
  assign dump_last = (idx_r == count_r - bole_pkg::CNT_W'(1));
  assign seen[0]   = 1'b0;

  // Status and new count of a single-result request.
  always_comb begin
    status    = bole_pkg::ST_OK;
    count_nxt = count_r;
    case (in_action)
      bole_pkg::ACT_INS_HEAD: begin
        if (range_bad) begin
          status = bole_pkg::ST_RANGE;
        end else if (full) begin
          status = bole_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + bole_pkg::CNT_W'(1);
        end
      end
      bole_pkg::ACT_APPEND: begin
        if (full) begin
          status = bole_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + bole_pkg::CNT_W'(1);
        end
      end
      bole_pkg::ACT_DELETE: begin
        if (empty) begin
          status = bole_pkg::ST_EMPTY;
        end else if (!found) begin
          status = bole_pkg::ST_NOTFOUND;
        end else begin
          count_nxt = count_r - bole_pkg::CNT_W'(1);
        end
      end
      bole_pkg::ACT_CLEAR: begin
        count_nxt = '0;
      end
      bole_pkg::ACT_DUMP: begin
        if (empty) begin
          status = bole_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell control: the operation is shared but for append; position flags are per cell.
  always_comb begin
    for (int i = 0; i < bole_pkg::LIST_DEPTH; i++) begin
      cell_ctl[i].valid = (bole_pkg::CNT_W'(i) < count_r);
      cell_ctl[i].wrap  = (bole_pkg::CNT_W'(i) == count_r - bole_pkg::CNT_W'(1));
      cell_ctl[i].op    = bole_pkg::CELL_KEEP;
      if (busy) begin
        cell_ctl[i].op = bole_pkg::CELL_ROTATE;
      end else if (accept) begin
        case (in_action)
          bole_pkg::ACT_INS_HEAD: begin
            if (!range_bad && !full) begin
              cell_ctl[i].op = bole_pkg::CELL_SHIFT;
            end
          end
          bole_pkg::ACT_APPEND: begin
            if (!full && (bole_pkg::CNT_W'(i) == count_r)) begin
              cell_ctl[i].op = bole_pkg::CELL_LOAD;
            end
          end
          bole_pkg::ACT_DELETE: begin
            cell_ctl[i].op = bole_pkg::CELL_DELETE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The chain of cells, head at cell 0.
  for (genvar g = 0; g < bole_pkg::LIST_DEPTH; g++) begin : g_cell
    logic [bole_pkg::VAL_W-1:0] left_value;
    logic [bole_pkg::VAL_W-1:0] right_value;

    if (g == 0) begin : g_head
      assign left_value = req_value;
    end else begin : g_body
      assign left_value = cell_value[g-1];
    end

    if (g == bole_pkg::LIST_DEPTH - 1) begin : g_tail
      assign right_value = cell_value[0];
    end else begin : g_mid
      assign right_value = cell_value[g+1];
    end

    bole_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[g]),
      .in_value    (req_value),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_value[0]),
      .seen_in     (seen[g]),
      .seen_out    (seen[g+1]),
      .entry_value (cell_value[g])
    );
  end

  // State, count and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if ((in_action == bole_pkg::ACT_DUMP) && !empty) begin
              state_r <= S_DUMP;
              idx_r   <= '0;
            end else begin
              count_r      <= count_nxt;
              out_valid_r  <= 1'b1;
              out_status_r <= status;
              out_value_r  <= '0;
              out_count_r  <= count_nxt;
              out_last_r   <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          out_valid_r  <= 1'b1;
          out_status_r <= bole_pkg::ST_OK;
          out_value_r  <= cell_value[0];
          out_count_r  <= count_r;
          out_last_r   <= dump_last;
          idx_r        <= idx_r + bole_pkg::CNT_W'(1);
          if (dump_last) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_entry_count = 5'(out_count_r);
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // A request that is not a dump of a live list gives one final result next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !((in_action == bole_pkg::ACT_DUMP) && !empty))
      |=> (out_valid && out_last))
    else $error("single-result request did not give a final result");

  // The count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bole_pkg::CNT_W'(bole_pkg::LIST_DEPTH))
    else $error("entry count beyond list depth");

  // A dump only runs over a live list and stays within it.
  a_dump_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (!empty && (idx_r < count_r)))
    else $error("dump running past the list");

  // Results with a status other than ok, which are never dump entries, carry a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bole_pkg::ST_OK)) |-> (out_entry_value == '0))
    else $error("non-ok result with nonzero value");
`endif

endmodule

// ===== rtl/bole_cell.sv =====
// One cell of the list chain: holds one entry and compares it with the request.
// Passes the first-match flag on to its right neighbor.
// Depends on bole_pkg.
module bole_cell (
  input  logic                        clk,
  input  bole_pkg::cell_ctl_t         ctl,
  input  logic [bole_pkg::VAL_W-1:0]  in_value,
  input  logic [bole_pkg::VAL_W-1:0]  left_value,
  input  logic [bole_pkg::VAL_W-1:0]  right_value,
  input  logic [bole_pkg::VAL_W-1:0]  head_value,
  input  logic                        seen_in,
  output logic                        seen_out,
  output logic [bole_pkg::VAL_W-1:0]  entry_value
);

  logic [bole_pkg::VAL_W-1:0] entry_r;
  logic [bole_pkg::VAL_W-1:0] entry_nxt;
  logic                       hit;

  // A live entry equal to the request value is a match.
  assign hit         = ctl.valid && (entry_r == in_value);
  assign seen_out    = seen_in || hit;
  assign entry_value = entry_r;

  // Select the next entry from the neighbors or the request.
  always_comb begin
    unique case (ctl.op)
      bole_pkg::CELL_KEEP:   entry_nxt = entry_r;
      bole_pkg::CELL_SHIFT:  entry_nxt = left_value;
      bole_pkg::CELL_LOAD:   entry_nxt = in_value;
      bole_pkg::CELL_DELETE: entry_nxt = (seen_in || hit) ? right_value : entry_r;
      bole_pkg::CELL_ROTATE: entry_nxt = ctl.wrap ? head_value : right_value;
      default:               entry_nxt = entry_r;
    endcase
  end

  // Entry storage needs no reset; only live entries are ever read.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
